// ----- hdl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned PrioW        = 16;
  localparam int unsigned OccW         = 5;
  localparam int unsigned DefaultDepth = 16;

  localparam logic KindInsert  = 1'b0;
  localparam logic KindExtract = 1'b1;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatOverflow = 2'd1,
    StatEmpty    = 2'd2
  } status_e;

  // one queue slot as held in the slot memory
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic        [PrioW-1:0] prio;
  } entry_t;

  localparam int unsigned EntryW = DataW + PrioW;

endpackage

// ----- hdl/spq_if.sv -----
// Valid/ready channel interfaces for the queue's request and result items.
// Depends on spq_pkg for field widths and the status type.
`timescale 1ns / 1ps

interface spq_req_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [spq_pkg::DataW-1:0]  item_value;
  logic        [spq_pkg::PrioW-1:0]  item_priority;

  modport source (output valid, kind, item_value, item_priority, input ready);
  modport sink   (input valid, kind, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [spq_pkg::DataW-1:0]  out_value;
  spq_pkg::status_e                  status;
  logic        [spq_pkg::OccW-1:0]   occupancy;

  modport source (output valid, out_value, status, occupancy, input ready);
  modport sink   (input valid, out_value, status, occupancy, output ready);
endinterface

// ----- hdl/spq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/sorted_priority_queue_unit.sv -----
// Sorted priority queue: request channel in, result channel out.
// Depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_ram.
//
// Usage: each request item is an insert (value, priority) or an extract of
// the highest-priority value; every request yields exactly one result item
// with out_value, status and the occupancy after the operation. Entries of
// equal priority leave in arrival order. Insert into a full queue returns
// overflow, extract from an empty queue returns empty; both leave it as is.
// One item is handled at a time. An insert moves each lower-priority entry
// back one slot before placing the new one; an extract reads the head and
// then moves every remaining entry forward one slot. Refused cases and an
// insert into an empty queue go straight to the finish state.
// Slots move one per cycle through the slot memory (one write, one read port),
// driven by one shared priority comparator and slot address counter.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, a finished item holds before the
// register until it frees. Reset empties the queue; slot contents are not
// cleared, as only slots below the occupancy are ever read.
`timescale 1ns / 1ps

module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_req_if.sink     in_i,
  spq_rsp_if.source   out_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StInsCmp   = 3'd1;
  localparam logic [2:0] StInsPlace = 3'd2;
  localparam logic [2:0] StExtHead  = 3'd3;
  localparam logic [2:0] StExtShift = 3'd4;
  localparam logic [2:0] StFinish   = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          pos_q, pos_d;
  spq_pkg::entry_t          new_q, new_d;
  logic signed [spq_pkg::DataW-1:0] res_value_q, res_value_d;
  spq_pkg::status_e         res_status_q, res_status_d;

  logic                             out_valid_q, out_valid_d;
  logic signed [spq_pkg::DataW-1:0] out_value_q, out_value_d;
  spq_pkg::status_e                 out_status_q, out_status_d;
  logic [spq_pkg::OccW-1:0]         out_occ_q, out_occ_d;

  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr;
  logic [AddrW-1:0]         ram_raddr;
  spq_pkg::entry_t          ram_wdata;
  spq_pkg::entry_t          ram_rdata;
  logic [spq_pkg::EntryW-1:0] ram_rdata_raw;

  logic                     accept;
  logic                     load_out;
  logic                     move_back;

  spq_ram #(
    .Width (spq_pkg::EntryW),
    .Depth (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = spq_pkg::entry_t'(ram_rdata_raw);

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign load_out   = (state_q == StFinish) && (!out_valid_q || out_o.ready);
  // shared comparator: does the slot just read yield to the new entry?
  assign move_back  = (ram_rdata.prio < new_q.prio);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    new_d        = new_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = new_q;
    ram_raddr    = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          new_d.value  = in_i.item_value;
          new_d.prio   = in_i.item_priority;
          res_value_d  = '0;
          res_status_d = spq_pkg::StatOk;
          if (in_i.kind == spq_pkg::KindInsert) begin
            if (count_q >= CntW'(DEPTH)) begin
              res_status_d = spq_pkg::StatOverflow;
              state_d      = StFinish;
            end else if (count_q == '0) begin
              ram_we          = 1'b1;
              ram_waddr       = '0;
              ram_wdata.value = in_i.item_value;
              ram_wdata.prio  = in_i.item_priority;
              count_d         = CntW'(1);
              state_d         = StFinish;
            end else begin
              pos_d     = count_q;
              ram_raddr = AddrW'(count_q - CntW'(1));
              state_d   = StInsCmp;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = spq_pkg::StatEmpty;
              state_d      = StFinish;
            end else begin
              ram_raddr = '0;
              state_d   = StExtHead;
            end
          end
        end
      end

      StInsCmp: begin
        ram_we    = 1'b1;
        ram_waddr = AddrW'(pos_q);
        if (move_back) begin
          // shift the lower-priority slot back and look one slot further ahead
          ram_wdata = ram_rdata;
          pos_d     = pos_q - CntW'(1);
          if (pos_q == CntW'(1)) begin
            state_d = StInsPlace;
          end else begin
            ram_raddr = AddrW'(pos_q - CntW'(2));
          end
        end else begin
          count_d = count_q + CntW'(1);
          state_d = StFinish;
        end
      end

      StInsPlace: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_d   = count_q + CntW'(1);
        state_d   = StFinish;
      end

      StExtHead: begin
        res_value_d = ram_rdata.value;
        if (count_q == CntW'(1)) begin
          count_d = '0;
          state_d = StFinish;
        end else begin
          ram_raddr = AddrW'(1);
          pos_d     = '0;
          state_d   = StExtShift;
        end
      end

      StExtShift: begin
        // pos_q walks the slot being refilled from the one behind it
        ram_we    = 1'b1;
        ram_waddr = AddrW'(pos_q);
        ram_wdata = ram_rdata;
        if ((pos_q + CntW'(2)) < count_q) begin
          ram_raddr = AddrW'(pos_q + CntW'(2));
          pos_d     = pos_q + CntW'(1);
        end else begin
          count_d = count_q - CntW'(1);
          state_d = StFinish;
        end
      end

      StFinish: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    if (load_out) begin
      out_valid_d  = 1'b1;
      out_value_d  = res_value_q;
      out_status_d = res_status_q;
      out_occ_d    = spq_pkg::OccW'(count_q);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q        <= new_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.occupancy = out_occ_q;

endmodule

// ----- tb/sv/tb_sorted_priority_queue_unit.sv -----
// Self-checking testbench for sorted_priority_queue_unit: directed and random
// insert/extract items under varying source idling and sink stalls.
// Depends on spq_pkg, spq_if and the RTL of the queue.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;

  localparam int unsigned Depth      = spq_pkg::DefaultDepth;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainWait  = 40;

  typedef struct packed {
    logic signed [spq_pkg::DataW-1:0] value;
    spq_pkg::status_e                 status;
    logic        [spq_pkg::OccW-1:0]  occupancy;
  } pq_result_t;

  logic clk;
  logic rst_n;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue_unit #(
    .DEPTH (Depth)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // shadow copy of the sorted slot array, slot 0 is served first
  logic signed [spq_pkg::DataW-1:0] shadow_value [Depth];
  logic        [spq_pkg::PrioW-1:0] shadow_prio  [Depth];
  int unsigned                      shadow_count;

  pq_result_t pending_results [$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned n_insert;
  int unsigned n_extract;
  int unsigned n_refused;
  int unsigned n_empty;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic pq_result_t queue_step(
    input logic                             kind,
    input logic signed [spq_pkg::DataW-1:0] value,
    input logic        [spq_pkg::PrioW-1:0] prio
  );
    pq_result_t  res;
    int unsigned pos;
    res.value = '0;
    res.status = spq_pkg::StatOk;
    if (kind == spq_pkg::KindInsert) begin
      if (shadow_count >= Depth) begin
        res.status = spq_pkg::StatOverflow;
      end else begin
        // shift lower priorities back, stop behind an equal one
        pos = shadow_count;
        while (pos > 0 && shadow_prio[pos-1] < prio) begin
          shadow_value[pos] = shadow_value[pos-1];
          shadow_prio[pos]  = shadow_prio[pos-1];
          pos--;
        end
        shadow_value[pos] = value;
        shadow_prio[pos]  = prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = spq_pkg::StatEmpty;
      end else begin
        res.value = shadow_value[0];
        for (int k = 0; k + 1 < shadow_count; k++) begin
          shadow_value[k] = shadow_value[k+1];
          shadow_prio[k]  = shadow_prio[k+1];
        end
        shadow_count--;
      end
    end
    res.occupancy = shadow_count[spq_pkg::OccW-1:0];
    return res;
  endfunction

  task automatic send_item(
    input logic                             kind,
    input logic signed [spq_pkg::DataW-1:0] value,
    input logic        [spq_pkg::PrioW-1:0] prio
  );
    pq_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
    @(negedge clk);
    req_if.valid         = 1'b1;
    req_if.kind          = kind;
    req_if.item_value    = value;
    req_if.item_priority = prio;
    do @(posedge clk); while (!req_if.ready);
    res = queue_step(kind, value, prio);
    pending_results.push_back(res);
    if (kind == spq_pkg::KindInsert) n_insert++;
    else n_extract++;
    if (res.status == spq_pkg::StatOverflow) n_refused++;
    if (res.status == spq_pkg::StatEmpty) n_empty++;
  endtask

  // sink side: stall at random, decided at each falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      rsp_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    pq_result_t got;
    pq_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.value     = rsp_if.out_value;
      got.status    = rsp_if.status;
      got.occupancy = rsp_if.occupancy;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result value=%0d status=%s occupancy=%0d",
                   $realtime, got.value, got.status.name(), got.occupancy);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result mismatch: expected value=%0d status=%s occ=%0d,",
                     $realtime, want.value, want.status.name(), want.occupancy,
                     " got value=%0d status=%s occ=%0d",
                     got.value, got.status.name(), got.occupancy);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(spq_pkg::KindExtract, 32'sh1234_5678, 16'h1234);
    send_item(spq_pkg::KindInsert, 32'sh7fff_ffff, 16'hffff);
    send_item(spq_pkg::KindInsert, 32'sh8000_0000, 16'h0000);
    // equal priorities must leave in arrival order
    send_item(spq_pkg::KindInsert, 32'sh0000_0000, 16'h8000);
    send_item(spq_pkg::KindInsert, -32'sd1, 16'h8000);
    send_item(spq_pkg::KindInsert, 32'sh0000_0001, 16'h8000);
    for (int i = 0; i < Depth - 5; i++) begin
      case (i % 3)
        0: send_item(spq_pkg::KindInsert, $urandom, 16'hffff);
        1: send_item(spq_pkg::KindInsert, $urandom, 16'h0000);
        default: send_item(spq_pkg::KindInsert, $urandom, 16'h8000);
      endcase
    end
    // queue full: both must be refused
    send_item(spq_pkg::KindInsert, 32'sh5a5a_5a5a, 16'hffff);
    send_item(spq_pkg::KindInsert, 32'sha5a5_a5a5, 16'h0000);
    repeat (4) send_item(spq_pkg::KindExtract, $urandom, spq_pkg::PrioW'($urandom));
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned src_pct,
                            input int unsigned snk_pct);
    bit                        filling;
    logic                      kind;
    logic [spq_pkg::PrioW-1:0] prio;
    int unsigned               pick;
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    filling        = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      // sweep between full and empty so both refusals are reached often
      if (shadow_count == Depth) filling = 1'b0;
      if (shadow_count == 0) filling = 1'b1;
      if ($urandom_range(49) == 0) filling = !filling;
      pick = $urandom_range(99);
      if (pick < 10) kind = 1'($urandom_range(1));
      else kind = (pick < 75) ? (filling ? spq_pkg::KindInsert : spq_pkg::KindExtract)
                              : (filling ? spq_pkg::KindExtract : spq_pkg::KindInsert);
      // few distinct priorities half the time to force ties
      if ($urandom_range(1)) prio = spq_pkg::PrioW'($urandom_range(3));
      else prio = spq_pkg::PrioW'($urandom);
      send_item(kind, $urandom, prio);
    end
  endtask

  task automatic test_random_no_idle();
    run_random(260, 0, 0);
  endtask

  task automatic test_random_source_idle();
    run_random(260, 53, 0);
  endtask

  task automatic test_random_sink_stall();
    run_random(260, 0, 53);
  endtask

  task automatic test_random_both_idle();
    run_random(260, 16, 16);
  endtask

  initial begin
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.kind          = spq_pkg::KindInsert;
    req_if.item_value    = '0;
    req_if.item_priority = '0;
    rsp_if.ready         = 1'b0;
    src_idle_pct         = 0;
    sink_stall_pct       = 0;
    mismatches           = 0;
    results_seen         = 0;
    n_insert             = 0;
    n_extract            = 0;
    n_refused            = 0;
    n_empty              = 0;
    shadow_count         = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_no_idle();
    test_random_source_idle();
    test_random_sink_stall();
    test_random_both_idle();

    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Ran %0d inserts (%0d refused as full) and %0d extracts (%0d on empty),",
             n_insert, n_refused, n_extract, n_empty);
    $display("checked %0d results over four idle/stall mixes; %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
